### src/sdo_pkg.sv
// types and constants shared by the segmented download receiver
// no dependencies
package sdo_pkg;

  // sdo command specifiers
  localparam logic [7:0] CMD_INITIATE = 8'h21;
  localparam logic [7:0] CMD_SEG_T0   = 8'h00;
  localparam logic [7:0] CMD_SEG_T1   = 8'h10;
  localparam logic [7:0] CMD_SEG_ANY  = 8'h03;

  // acknowledge bytes
  localparam logic [7:0] ACK_INIT_B0  = 8'h60;
  localparam logic [7:0] ACK_INIT_B1  = 8'h20;
  localparam logic [7:0] ACK_SEG_T0   = 8'h20;
  localparam logic [7:0] ACK_SEG_T1   = 8'h30;

  localparam int unsigned SEG_BYTES = 7;
  localparam int unsigned MAX_WORDS = 4;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0]  command_byte;
    logic [55:0] payload;
  } in_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [15:0] data_word;
    logic [7:0]  ack_byte0;
    logic [7:0]  ack_byte1;
    logic        last;
  } out_t;

endpackage

### src/sdo_segmented_download_receiver.sv
// segmented download receiver, server side of an sdo segmented download
// depends on sdo_pkg
//
// usage:
//   in channel (in_valid/in_ready/in_data) carries one received can frame per
//   transaction: command byte plus bytes 1 to 7.
//   out channel (out_valid/out_ready/out_data) carries the results of a frame:
//   zero to four data words, then one acknowledge or reject with last set.
//   a frame is decoded in the cycle it is accepted; all of its results are
//   captured in a result buffer and the first one is offered on the next cycle.
//   results leave one per cycle while out_ready is high, so a frame occupies the
//   buffer until all of its results (words produced plus one) are taken. a new
//   frame is taken in the same cycle the last result of the previous frame is
//   taken, so frames that yield a single result flow at one per cycle while out_ready is high.
//   when out_ready is low the buffer holds its current result and in_ready
//   stays low until the final result of the frame has been taken.
//   reset (rst_n low, synchronous) clears the byte count, the toggle, the
//   held byte and empties the result buffer.
module sdo_segmented_download_receiver
  import sdo_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // transfer state
  logic [31:0] rem_r, rem_nxt;
  logic        tog_r, tog_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        hv_r, hv_nxt;

  // result buffer
  logic        busy_r;
  logic [2:0]  ptr_r;
  logic [2:0]  nwords_r, nwords_nxt;
  logic [15:0] words_r [MAX_WORDS];
  logic [15:0] words_nxt [MAX_WORDS];
  kind_t       fin_kind_r, fin_kind_nxt;
  logic [7:0]  fin_ack0_r, fin_ack0_nxt;
  logic [7:0]  fin_ack1_r, fin_ack1_nxt;

  logic        in_fire, out_fire, is_final;
  logic [7:0]  pay_b [SEG_BYTES];
  logic [2:0]  take_n;
  logic [3:0]  total_b;
  logic [2:0]  last_idx;
  logic        seg_ok;

  assign is_final = (ptr_r == nwords_r);
  assign out_valid = busy_r;
  assign out_fire = busy_r && out_ready;
  assign in_ready = !busy_r || (out_ready && is_final);
  assign in_fire = in_valid && in_ready;

  // split payload into bytes
  always_comb begin
    for (int i = 0; i < SEG_BYTES; i++) begin
      pay_b[i] = in_data.payload[8*i +: 8];
    end
  end

  // frame decode
  always_comb begin
    rem_nxt      = rem_r;
    tog_nxt      = tog_r;
    held_nxt     = held_r;
    hv_nxt       = hv_r;
    nwords_nxt   = 3'd0;
    fin_kind_nxt = KIND_REJECT;
    fin_ack0_nxt = 8'h00;
    fin_ack1_nxt = 8'h00;
    take_n       = (rem_r >= 32'(SEG_BYTES)) ? 3'(SEG_BYTES) : rem_r[2:0];
    total_b      = {1'b0, take_n} + {3'b000, hv_r};
    last_idx     = take_n - 3'd1;
    seg_ok       = (!tog_r && in_data.command_byte == CMD_SEG_T0) ||
                   (tog_r && in_data.command_byte == CMD_SEG_T1) ||
                   (in_data.command_byte == CMD_SEG_ANY);

    // pair held byte and payload bytes little-endian
    for (int k = 0; k < MAX_WORDS; k++) begin
      if (hv_r) begin
        words_nxt[k][7:0]  = (k == 0) ? held_r : pay_b[(2*k+SEG_BYTES-1) % SEG_BYTES];
        words_nxt[k][15:8] = pay_b[(2*k) % SEG_BYTES];
      end else begin
        words_nxt[k][7:0]  = pay_b[(2*k) % SEG_BYTES];
        words_nxt[k][15:8] = (k == MAX_WORDS-1) ? 8'h00 : pay_b[(2*k+1) % SEG_BYTES];
      end
    end

    if (rem_r == 32'd0) begin
      if (in_data.command_byte == CMD_INITIATE) begin
        rem_nxt      = in_data.payload[55:24];
        fin_kind_nxt = KIND_ACK;
        fin_ack0_nxt = ACK_INIT_B0;
        fin_ack1_nxt = ACK_INIT_B1;
      end
    end else if (seg_ok) begin
      rem_nxt      = rem_r - {29'd0, take_n};
      nwords_nxt   = total_b[3:1];
      hv_nxt       = total_b[0];
      held_nxt     = total_b[0] ? in_data.payload[8*last_idx +: 8] : 8'h00;
      tog_nxt      = !tog_r;
      fin_kind_nxt = KIND_ACK;
      fin_ack0_nxt = tog_r ? ACK_SEG_T1 : ACK_SEG_T0;
    end
  end

  // state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 32'd0;
      tog_r  <= 1'b0;
      held_r <= 8'h00;
      hv_r   <= 1'b0;
      busy_r <= 1'b0;
      ptr_r  <= 3'd0;
    end else begin
      if (in_fire) begin
        rem_r  <= rem_nxt;
        tog_r  <= tog_nxt;
        held_r <= held_nxt;
        hv_r   <= hv_nxt;
        busy_r <= 1'b1;
        ptr_r  <= 3'd0;
      end else if (out_fire) begin
        if (is_final) begin
          busy_r <= 1'b0;
        end else begin
          ptr_r <= ptr_r + 3'd1;
        end
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      nwords_r   <= nwords_nxt;
      fin_kind_r <= fin_kind_nxt;
      fin_ack0_r <= fin_ack0_nxt;
      fin_ack1_r <= fin_ack1_nxt;
      for (int k = 0; k < MAX_WORDS; k++) begin
        words_r[k] <= words_nxt[k];
      end
    end
  end

  // current result
  always_comb begin
    if (is_final) begin
      out_data.result_kind = fin_kind_r;
      out_data.data_word   = 16'h0000;
      out_data.ack_byte0   = fin_ack0_r;
      out_data.ack_byte1   = fin_ack1_r;
      out_data.last        = 1'b1;
    end else begin
      out_data.result_kind = KIND_DATA;
      out_data.data_word   = words_r[ptr_r[1:0]];
      out_data.ack_byte0   = 8'h00;
      out_data.ack_byte1   = 8'h00;
      out_data.last        = 1'b0;
    end
  end

endmodule

### verif/sdo_segmented_download_receiver_tb.sv
// testbench for the segmented download receiver: directed and random can frames,
// results checked against an in-bench model of the sdo download state
// depends on sdo_pkg and sdo_segmented_download_receiver
`timescale 1ns / 1ps

module sdo_segmented_download_receiver_tb
  import sdo_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned MAX_GAP     = 18;

  // tracks the download state and the results each frame owes
  class download_tracker;
    logic [31:0] bytes_left;
    bit          seg_toggle;
    logic [7:0]  held_byte;
    bit          held_valid;
    out_t        pending_results[$];
    int          frames_seen;
    int          results_checked;
    int          transfers;
    int          rejects;
    int          errors;

    function new();
      bytes_left      = '0;
      seg_toggle      = 1'b0;
      held_byte       = '0;
      held_valid      = 1'b0;
      frames_seen     = 0;
      results_checked = 0;
      transfers       = 0;
      rejects         = 0;
      errors          = 0;
    endfunction

    function void push_result(kind_t kind, logic [15:0] word, logic [7:0] b0,
                              logic [7:0] b1, logic fin);
      out_t r;
      r.result_kind = kind;
      r.data_word   = word;
      r.ack_byte0   = b0;
      r.ack_byte1   = b1;
      r.last        = fin;
      pending_results.push_back(r);
    endfunction

    // called for every accepted input transaction
    function void note_frame(in_t frame);
      logic [7:0] b;
      bit         take;
      frames_seen++;
      // idle: only an initiate is accepted
      if (bytes_left == 0) begin
        if (frame.command_byte == CMD_INITIATE) begin
          bytes_left = frame.payload[55:24];
          transfers++;
          push_result(KIND_ACK, '0, ACK_INIT_B0, ACK_INIT_B1, 1'b1);
        end else begin
          rejects++;
          push_result(KIND_REJECT, '0, '0, '0, 1'b1);
        end
        return;
      end
      take = (!seg_toggle && frame.command_byte == CMD_SEG_T0) ||
             (seg_toggle && frame.command_byte == CMD_SEG_T1) ||
             (frame.command_byte == CMD_SEG_ANY);
      if (!take) begin
        rejects++;
        push_result(KIND_REJECT, '0, '0, '0, 1'b1);
        return;
      end
      // take bytes up to the remaining count, pairing little-endian
      for (int i = 0; i < SEG_BYTES && bytes_left != 0; i++) begin
        b = frame.payload[8*i +: 8];
        if (held_valid) begin
          push_result(KIND_DATA, {b, held_byte}, '0, '0, 1'b0);
          held_valid = 1'b0;
          held_byte  = '0;
        end else begin
          held_byte  = b;
          held_valid = 1'b1;
        end
        bytes_left--;
      end
      push_result(KIND_ACK, '0, seg_toggle ? ACK_SEG_T1 : ACK_SEG_T0, '0, 1'b1);
      seg_toggle = ~seg_toggle;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    // called for every accepted output transaction
    function void check_result(out_t got);
      out_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none owed, expected nothing, got %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
      compare_field("data_word", want.data_word, got.data_word);
      compare_field("ack_byte0", 16'(want.ack_byte0), 16'(got.ack_byte0));
      compare_field("ack_byte1", 16'(want.ack_byte1), 16'(got.ack_byte1));
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  bit              brisk;
  bit              long_hold_done;
  download_tracker tracker;

  sdo_segmented_download_receiver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [55:0] random_payload();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[55:0];
  endfunction

  // offer one frame, holding it until accepted; called at a rising edge
  task automatic send_frame(input logic [7:0] cmd, input logic [55:0] pay);
    int   gap;
    in_t  frame;
    frame.command_byte = cmd;
    frame.payload      = pay;
    gap = brisk ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_frame(frame);
  endtask

  // sender pauses until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  // one download: optional idle noise, initiate, then segments with some noise
  task automatic run_transfer(input logic [31:0] count);
    int unsigned pick;
    logic [7:0]  cmd;
    if ($urandom_range(0, 5) == 0) begin
      cmd = 8'($urandom_range(0, 255));
      if (cmd == CMD_INITIATE) cmd = CMD_SEG_T0;
      send_frame(cmd, random_payload());
    end
    send_frame(CMD_INITIATE, {count, 24'(random_payload())});
    while (tracker.bytes_left != 0) begin
      pick = $urandom_range(0, 11);
      case (pick)
        0: cmd = 8'($urandom_range(0, 255));
        1: cmd = tracker.seg_toggle ? CMD_SEG_T0 : CMD_SEG_T1;
        2: cmd = CMD_INITIATE;
        3, 4: cmd = CMD_SEG_ANY;
        default: cmd = tracker.seg_toggle ? CMD_SEG_T1 : CMD_SEG_T0;
      endcase
      send_frame(cmd, random_payload());
    end
  endtask

  task automatic random_downloads(input int frame_target);
    logic [31:0] count;
    while (tracker.frames_seen < frame_target) begin
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120) : $urandom_range(0, 30);
      run_transfer(count);
    end
  endtask

  // result side: random stalls, one long hold-off to back up the input
  initial begin : result_sink
    int wait_cycles;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!long_hold_done && tracker.results_checked >= 120) begin
        wait_cycles    = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        wait_cycles = brisk ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      tracker.check_result(out_data);
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycles,
             tracker.pending_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    tracker        = new();
    brisk          = 1'b0;
    long_hold_done = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle rejects, zero count, odd count, wrong toggle, busy initiate
    send_frame(CMD_SEG_T0, {56{1'b1}});
    send_frame(8'hFF, '0);
    send_frame(CMD_INITIATE, {32'd0, 24'hFF_FFFF});
    send_frame(CMD_SEG_ANY, random_payload());
    send_frame(CMD_INITIATE, {32'd3, 24'h00_0000});
    send_frame(CMD_SEG_T1, random_payload());
    send_frame(CMD_INITIATE, {32'd5, 24'h12_3456});
    // short final segment leaves a byte held
    send_frame(CMD_SEG_T0, {56{1'b1}});
    // toggle carries into the next download, held byte pairs with its first byte
    send_frame(CMD_INITIATE, {32'd9, 24'hAB_CDEF});
    send_frame(CMD_SEG_T0, random_payload());
    send_frame(CMD_SEG_T1, {56{1'b1}});
    send_frame(CMD_SEG_ANY, '0);
    send_frame(CMD_INITIATE, {32'd7, 24'h00_0001});
    send_frame(CMD_SEG_T1, {7{8'hAA}});
    send_frame(CMD_SEG_T0, {7{8'h55}});
    send_frame(CMD_SEG_ANY, random_payload());

    // random downloads with random stalls on both sides
    random_downloads(200);
    drain_results();
    // no idling on either side
    brisk = 1'b1;
    random_downloads(290);
    drain_results();
    brisk = 1'b0;
    random_downloads(465);

    // largest count, a few segments and an initiate while busy
    send_frame(CMD_INITIATE, {32'hFFFF_FFFF, 24'h00_0000});
    send_frame(tracker.seg_toggle ? CMD_SEG_T1 : CMD_SEG_T0, {56{1'b1}});
    send_frame(CMD_SEG_ANY, '0);
    send_frame(CMD_INITIATE, {56{1'b1}});
    send_frame(tracker.seg_toggle ? CMD_SEG_T1 : CMD_SEG_T0, random_payload());
    drain_results();
    repeat (10) @(posedge clk);

    $display("run covered %0d frames, %0d downloads started, %0d rejects, %0d results",
             tracker.frames_seen, tracker.transfers, tracker.rejects,
             tracker.results_checked);
    $display("long output hold-off %0s, %0d mismatches",
             long_hold_done ? "done" : "missed", tracker.errors);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
